[sv/rvsc_pkg.sv]
// Shared types and constants for the RISC-V SYSTEM/CSR unit.
`default_nettype none

package rvsc_pkg;

   // Result action codes
   typedef enum logic [2:0] {
      ACT_NONE      = 3'd0,
      ACT_ECALL     = 3'd1,
      ACT_EBREAK    = 3'd2,
      ACT_STOP      = 3'd3,
      ACT_ILLEGAL   = 3'd4,
      ACT_UNIMP     = 3'd5,
      ACT_UNHANDLED = 3'd6
   } action_type;

   // funct3 codes of the SYSTEM opcode
   localparam logic [2:0] F3_PRIV   = 3'd0;
   localparam logic [2:0] F3_CSRRW  = 3'd1;
   localparam logic [2:0] F3_CSRRS  = 3'd2;
   localparam logic [2:0] F3_CSRRC  = 3'd3;
   localparam logic [2:0] F3_ZIMOP  = 3'd4;
   localparam logic [2:0] F3_CSRRWI = 3'd5;
   localparam logic [2:0] F3_CSRRSI = 3'd6;
   localparam logic [2:0] F3_CSRRCI = 3'd7;

   // funct3 == 0 immediates
   localparam logic [11:0] SYS_ECALL   = 12'h000;
   localparam logic [11:0] SYS_EBREAK  = 12'h001;
   localparam logic [11:0] SYS_WFI     = 12'h105;
   localparam logic [11:0] SYS_STOP    = 12'h7FF;
   localparam logic [11:0] SYS_WRS_NTO = 12'h00D;
   localparam logic [11:0] SYS_WRS_STO = 12'h01D;

   // CSR numbers
   localparam logic [11:0] CSR_FFLAGS   = 12'h001;
   localparam logic [11:0] CSR_FRM      = 12'h002;
   localparam logic [11:0] CSR_FCSR     = 12'h003;
   localparam logic [11:0] CSR_CYCLE    = 12'hC00;
   localparam logic [11:0] CSR_TIME     = 12'hC01;
   localparam logic [11:0] CSR_INSTRET  = 12'hC02;
   localparam logic [11:0] CSR_CYCLEH   = 12'hC80;
   localparam logic [11:0] CSR_TIMEH    = 12'hC81;
   localparam logic [11:0] CSR_INSTRETH = 12'hC82;
   localparam logic [11:0] CSR_PRIV_MASK = 12'h300;

   // Zimop encoding check on instruction[31:25]
   localparam logic [6:0] MOP_MASK  = 7'b1011000;
   localparam logic [6:0] MOP_MATCH = 7'b1000000;

   typedef struct packed {
      logic        dw;
      logic [63:0] dv;
      action_type  act;
      logic [63:0] info;
      logic [4:0]  sidx;
   } res_type;

   localparam res_type RES_NONE = '{dw: 1'b0, dv: 64'd0, act: ACT_NONE,
                                    info: 64'd0, sidx: 5'd0};

endpackage

`default_nettype wire

[sv/riscv_system_csr_unit_top.sv]
// RISC-V SYSTEM-opcode decoder and user floating-point/counter CSR unit.
`default_nettype none

// One SYSTEM instruction per transfer on the req_ stream, one result per
// transfer on the rsp_ stream. The unit takes a new instruction every cycle
// while its result register is empty or being taken: the request lands in
// an input register, a single pass of decode logic works on it together
// with the kept fcsr register, and the outcome is loaded into the result
// register at the same edge that fcsr takes its new value, so the next
// instruction always sees the updated fflags/frm. Both registers advance
// whenever the result register is empty or being taken; while a result is
// held, one more request can still enter an empty input register.
// fcsr (fflags in bits 4:0, frm in bits 7:5) is cleared by reset. Counter
// and time reads come straight from the request fields; CSR faults,
// ECALL/EBREAK/stop and unhandled user CSRs are reported through the
// action code with its info word. XLEN sets the width of the integer
// register file that source, a7 and destination values are masked to.

module riscv_system_csr_unit_top
   import rvsc_pkg::*;
#(
   parameter int XLEN = 64
) (
   input  wire logic         clock,
   input  wire logic         reset,
   // tdata: instruction[31:0], source_value[95:32], a7_value[159:96],
   //        retired_count[223:160], time_value[287:224]
   input  wire logic [287:0] req_tdata,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   // tdata: dest_index[4:0], dest_value[68:5], action_info[132:69],
   //        source_index[137:133], zero[143:138]
   output logic [143:0]      rsp_tdata,
   // tuser: dest_write[0], action[3:1]
   output logic [3:0]        rsp_tuser,
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready
);

   localparam logic [63:0] XMASK = (XLEN >= 64) ? {64{1'b1}}
                                                : ((64'd1 << XLEN) - 64'd1);

   // input register
   logic        s1_valid_ff;
   logic [31:0] s1_instr_ff;
   logic [63:0] s1_src_ff;
   logic [63:0] s1_a7_ff;
   logic [63:0] s1_count_ff;
   logic [63:0] s1_time_ff;

   // result register and kept state
   logic        out_valid_ff;
   res_type     res_ff;
   // dest_index is the rd field of the item held in the result register
   logic [4:0]  rd_ff;
   logic [7:0]  fcsr_ff;

   logic        advance;
   res_type     res_in;
   logic [7:0]  fcsr_in;
   logic        fcsr_wr;

   // result register is free or draining this cycle
   assign advance    = !out_valid_ff || rsp_tready;
   assign req_tready = !s1_valid_ff || advance;

   function automatic res_type put_rd(input logic [4:0] rd, input logic [63:0] v);
      res_type r;
      r = RES_NONE;
      if (rd != 5'd0) begin
         r.dw = 1'b1;
         r.dv = v & XMASK;
      end
      return r;
   endfunction

   function automatic res_type raise(input action_type a, input logic [63:0] info);
      res_type r;
      r = RES_NONE;
      r.act  = a;
      r.info = info;
      return r;
   endfunction

   function automatic res_type unhandled(input logic [11:0] csr, input logic [4:0] rs1);
      res_type r;
      if ((csr & CSR_PRIV_MASK) != 12'd0) begin
         r = raise(ACT_ILLEGAL, {52'd0, csr});
      end else begin
         r = raise(ACT_UNHANDLED, {52'd0, csr});
         r.sidx = rs1;
      end
      return r;
   endfunction

   // time-low read: only legal without a source operand
   function automatic res_type time_read(input logic [11:0] csr, input logic [4:0] rd,
                                         input logic [4:0] rs1, input logic [63:0] tv);
      res_type r;
      if (rs1 != 5'd0) begin
         r = raise(ACT_ILLEGAL, {52'd0, csr});
      end else begin
         r = put_rd(rd, tv);
      end
      return r;
   endfunction

   function automatic res_type set_path(input logic [11:0] csr, input logic [4:0] rd,
                                        input logic [4:0] rs1, input logic [63:0] cnt,
                                        input logic [63:0] tv);
      res_type r;
      if (csr == CSR_CYCLE || csr == CSR_INSTRET) begin
         if (rd != 5'd0) begin
            r = put_rd(rd, cnt);
         end else if (rs1 == 5'd0) begin
            r = raise(ACT_UNIMP, {52'd0, csr});
         end else begin
            r = raise(ACT_ILLEGAL, {52'd0, csr});
         end
      end else if (csr == CSR_CYCLEH || csr == CSR_INSTRETH) begin
         r = put_rd(rd, {32'd0, cnt[63:32]});
      end else if (csr == CSR_TIME) begin
         r = time_read(csr, rd, rs1, tv);
      end else if (csr == CSR_TIMEH) begin
         r = put_rd(rd, {32'd0, tv[63:32]});
      end else begin
         r = unhandled(csr, rs1);
      end
      return r;
   endfunction

   // decode and execute
   always_comb begin
      logic [4:0]  rd;
      logic [2:0]  f3;
      logic [4:0]  rs1;
      logic [11:0] csr;
      logic [63:0] src;
      logic [63:0] a7;
      logic        is_fp;
      logic [7:0]  old_val;
      logic [7:0]  opnd;
      logic [7:0]  nv;
      logic [6:0]  hi;
      logic        mop_ok;

      rd  = s1_instr_ff[11:7];
      f3  = s1_instr_ff[14:12];
      rs1 = s1_instr_ff[19:15];
      csr = s1_instr_ff[31:20];
      src = s1_src_ff & XMASK;
      a7  = s1_a7_ff & XMASK;
      hi  = s1_instr_ff[31:25];
      mop_ok = ((hi & MOP_MASK) == MOP_MATCH)
               && (hi[0] || (s1_instr_ff[24:22] == 3'b111));

      is_fp = (csr == CSR_FFLAGS) || (csr == CSR_FRM) || (csr == CSR_FCSR);
      priority if (csr == CSR_FFLAGS) begin
         old_val = {3'd0, fcsr_ff[4:0]};
      end else if (csr == CSR_FRM) begin
         old_val = {5'd0, fcsr_ff[7:5]};
      end else begin
         old_val = fcsr_ff;
      end

      // register forms use x[rs1], immediate forms the rs1 field
      opnd = f3[2] ? {3'd0, rs1} : src[7:0];
      unique case (f3[1:0])
         2'b01:   nv = opnd;
         2'b10:   nv = old_val | opnd;
         default: nv = old_val & ~opnd;
      endcase

      priority if (csr == CSR_FFLAGS) begin
         fcsr_in = {fcsr_ff[7:5], nv[4:0]};
      end else if (csr == CSR_FRM) begin
         fcsr_in = {nv[2:0], fcsr_ff[4:0]};
      end else begin
         fcsr_in = nv;
      end

      res_in  = RES_NONE;
      fcsr_wr = 1'b0;

      unique case (f3)
         F3_PRIV: begin
            priority if (csr == SYS_ECALL) begin
               res_in = raise(ACT_ECALL, a7);
            end else if (csr == SYS_EBREAK) begin
               res_in = raise(ACT_EBREAK, 64'd0);
            end else if (csr == SYS_WFI || csr == SYS_STOP) begin
               res_in = raise(ACT_STOP, 64'd0);
            end else if (csr == SYS_WRS_NTO || csr == SYS_WRS_STO) begin
               res_in = RES_NONE;
            end else begin
               res_in = raise(ACT_ILLEGAL, {61'd0, f3});
            end
         end
         F3_ZIMOP: begin
            res_in = mop_ok ? put_rd(rd, 64'd0) : raise(ACT_ILLEGAL, {61'd0, f3});
         end
         F3_CSRRW: begin
            if (is_fp) begin
               res_in  = put_rd(rd, {56'd0, old_val});
               fcsr_wr = 1'b1;
            end else if (csr == CSR_TIME) begin
               res_in = raise(ACT_ILLEGAL, {52'd0, csr});
            end else begin
               res_in = set_path(csr, rd, rs1, s1_count_ff, s1_time_ff);
            end
         end
         F3_CSRRS, F3_CSRRSI: begin
            if (is_fp) begin
               res_in  = put_rd(rd, {56'd0, old_val});
               fcsr_wr = 1'b1;
            end else begin
               res_in = set_path(csr, rd, rs1, s1_count_ff, s1_time_ff);
            end
         end
         F3_CSRRC: begin
            if (is_fp) begin
               res_in  = put_rd(rd, {56'd0, old_val});
               fcsr_wr = 1'b1;
            end else if (csr == CSR_TIME) begin
               res_in = time_read(csr, rd, rs1, s1_time_ff);
            end else begin
               res_in = raise(ACT_ILLEGAL, {61'd0, f3});
            end
         end
         F3_CSRRWI: begin
            if (is_fp) begin
               res_in  = put_rd(rd, {56'd0, old_val});
               fcsr_wr = 1'b1;
            end else if (csr == CSR_TIME) begin
               res_in = raise(ACT_ILLEGAL, {52'd0, csr});
            end else begin
               res_in = unhandled(csr, rs1);
            end
         end
         F3_CSRRCI: begin
            if (is_fp) begin
               res_in  = put_rd(rd, {56'd0, old_val});
               fcsr_wr = 1'b1;
            end else if (csr == CSR_TIME) begin
               res_in = time_read(csr, rd, rs1, s1_time_ff);
            end else begin
               res_in = unhandled(csr, rs1);
            end
         end
      endcase
   end

   // input register: load on every accepted transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_tready) begin
         s1_valid_ff <= req_tvalid;
      end
      if (req_tvalid && req_tready) begin
         s1_instr_ff <= req_tdata[31:0];
         s1_src_ff   <= req_tdata[95:32];
         s1_a7_ff    <= req_tdata[159:96];
         s1_count_ff <= req_tdata[223:160];
         s1_time_ff  <= req_tdata[287:224];
      end
   end

   // result register and fcsr: commit together so the next item sees new fcsr
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         fcsr_ff      <= 8'd0;
      end else begin
         if (advance) begin
            out_valid_ff <= s1_valid_ff;
         end
         if (advance && s1_valid_ff && fcsr_wr) begin
            fcsr_ff <= fcsr_in;
         end
      end
      if (advance && s1_valid_ff) begin
         res_ff <= res_in;
         rd_ff  <= s1_instr_ff[11:7];
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {6'd0, res_ff.sidx, res_ff.info, res_ff.dv, rd_ff};
   assign rsp_tuser  = {res_ff.act, res_ff.dw};

   // a register write never comes with a fault or trap action
   a_write_no_action: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && res_ff.dw |-> res_ff.act == ACT_NONE)
      else $error("register write with nonzero action");

   // rs1 is reported only with the unhandled-CSR action
   a_sidx_unhandled: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && res_ff.sidx != 5'd0 |-> res_ff.act == ACT_UNHANDLED)
      else $error("source index set without unhandled action");

   // no destination write means a zero destination value
   a_dv_zero: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !res_ff.dw |-> res_ff.dv == 64'd0)
      else $error("destination value without write");

   // fcsr changes only when an item moves into the result register
   a_fcsr_commit: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) && fcsr_ff != $past(fcsr_ff) |-> $past(advance && s1_valid_ff))
      else $error("fcsr changed without an item commit");

endmodule

`default_nettype wire

[tb/sv/riscv_system_csr_unit_top_test.sv]
// Self-checking stream testbench for the SYSTEM-opcode and user CSR unit.
`timescale 1ns / 100ps

module riscv_system_csr_unit_top_test;
   import rvsc_pkg::*;

   localparam int          XLEN          = 64;
   localparam logic [63:0] XLEN_MASK     = (XLEN >= 64) ? {64{1'b1}} :
                                           ((64'd1 << XLEN) - 64'd1);
   localparam logic [6:0]  OPC_SYSTEM    = 7'b1110011;
   localparam int          IDLE_LIMIT    = 1000;
   localparam int          DRAIN_CYCLES  = 8;
   localparam int          RANDOM_ITEMS  = 1050;

   // Kind of update a CSR instruction applies to the floating-point status.
   typedef enum logic [1:0] {
      OP_WRITE,
      OP_SET,
      OP_CLEAR
   } csr_op_type;

   typedef struct packed {
      logic        dest_write;
      logic [4:0]  dest_index;
      logic [63:0] dest_value;
      action_type  action;
      logic [63:0] action_info;
      logic [4:0]  source_index;
   } csr_result_type;

   logic         clock      = 1'b0;
   logic         reset      = 1'b1;
   // tdata: instruction, source_value, a7_value, retired_count, time_value
   logic [287:0] req_tdata  = '0;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   // tdata: dest_index, dest_value, action_info, source_index, zero pad
   logic [143:0] rsp_tdata;
   // tuser: dest_write, action
   logic [3:0]   rsp_tuser;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;

   // Shadow of the unit's fcsr: frm in bits 7:5, fflags in bits 4:0.
   logic [7:0]   fcsr_shadow = 8'd0;
   csr_result_type  expected_results[$];
   csr_result_type  decoded;
   csr_result_type  oldest;
   int unsigned  fail_count  = 0;
   int unsigned  idle_cycles = 0;
   int unsigned  burst_left  = 0;
   int unsigned  rx_mode     = 0;
   int unsigned  rx_left     = 0;
   int unsigned  rx_tick     = 0;

   riscv_system_csr_unit_top #(.XLEN(XLEN)) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready)
   );

   always #10 clock = ~clock;

   // ---------------------------------------------------------------------
   // Prediction. The helpers below build up 'decoded' for one instruction
   // and advance fcsr_shadow exactly as the unit advances its fcsr.
   // ---------------------------------------------------------------------

   // Write rd unless it is x0; the value is cut to the integer width.
   function automatic void write_dest(input logic [63:0] value);
      if (decoded.dest_index != 5'd0) begin
         decoded.dest_write = 1'b1;
         decoded.dest_value = value & XLEN_MASK;
      end
   endfunction

   function automatic void raise_action(input action_type act, input logic [63:0] info);
      decoded.action      = act;
      decoded.action_info = info;
   endfunction

   // Apply a CSR op to fflags, frm or fcsr; return 0 for any other CSR.
   function automatic bit access_float_csr(input logic [11:0] csr, input csr_op_type op,
                                           input logic [63:0] operand);
      logic [63:0] old_value;
      logic [63:0] new_value;
      case (csr)
         CSR_FFLAGS: old_value = {59'd0, fcsr_shadow[4:0]};
         CSR_FRM:    old_value = {61'd0, fcsr_shadow[7:5]};
         CSR_FCSR:   old_value = {56'd0, fcsr_shadow};
         default:    return 1'b0;
      endcase
      case (op)
         OP_WRITE: new_value = operand;
         OP_SET:   new_value = old_value | operand;
         default:  new_value = old_value & ~operand;
      endcase
      write_dest(old_value);
      // Keep only the bits the addressed CSR owns.
      case (csr)
         CSR_FFLAGS: fcsr_shadow[4:0] = new_value[4:0];
         CSR_FRM:    fcsr_shadow[7:5] = new_value[2:0];
         default:    fcsr_shadow      = new_value[7:0];
      endcase
      return 1'b1;
   endfunction

   // Privileged CSRs fault; other user CSRs go out with rs1 attached.
   function automatic void report_unhandled(input logic [11:0] csr, input logic [4:0] rs1);
      if ((csr & CSR_PRIV_MASK) != 12'd0) begin
         raise_action(ACT_ILLEGAL, {52'd0, csr});
      end else begin
         raise_action(ACT_UNHANDLED, {52'd0, csr});
         decoded.source_index = rs1;
      end
   endfunction

   // Read path of CSRRS/CSRRSI, also taken by CSRRW on non-float CSRs other than time.
   function automatic void read_counter(input logic [11:0] csr, input logic [4:0] rs1,
                                        input logic [63:0] count, input logic [63:0] tval);
      case (csr)
         CSR_CYCLE, CSR_INSTRET: begin
            if (decoded.dest_index != 5'd0) write_dest(count);
            else if (rs1 == 5'd0) raise_action(ACT_UNIMP, {52'd0, csr});
            else raise_action(ACT_ILLEGAL, {52'd0, csr});
         end
         CSR_CYCLEH, CSR_INSTRETH: write_dest(count >> 32);
         CSR_TIME: begin
            if (rs1 != 5'd0) raise_action(ACT_ILLEGAL, {52'd0, csr});
            else write_dest(tval);
         end
         CSR_TIMEH: write_dest(tval >> 32);
         default:   report_unhandled(csr, rs1);
      endcase
   endfunction

   // Clear forms on time: only a read with a zero source field is legal.
   function automatic void clear_time(input logic [4:0] rs1, input logic [63:0] tval);
      if (rs1 != 5'd0) raise_action(ACT_ILLEGAL, {52'd0, CSR_TIME});
      else write_dest(tval);
   endfunction

   function automatic csr_result_type predict_system_op(input logic [287:0] word);
      logic [31:0] instr;
      logic [63:0] src;
      logic [63:0] a7;
      logic [63:0] count;
      logic [63:0] tval;
      logic [2:0]  f3;
      logic [4:0]  rs1;
      logic [11:0] csr;
      logic [63:0] imm;
      logic [6:0]  hi;
      instr = word[31:0];
      src   = word[95:32] & XLEN_MASK;
      a7    = word[159:96] & XLEN_MASK;
      count = word[223:160];
      tval  = word[287:224];
      f3    = instr[14:12];
      rs1   = instr[19:15];
      csr   = instr[31:20];
      imm   = {59'd0, rs1};
      hi    = instr[31:25];
      decoded = '{dest_write: 1'b0, dest_index: instr[11:7], dest_value: 64'd0,
                  action: ACT_NONE, action_info: 64'd0, source_index: 5'd0};
      case (f3)
         F3_PRIV: begin
            if (csr == SYS_ECALL) raise_action(ACT_ECALL, a7);
            else if (csr == SYS_EBREAK) raise_action(ACT_EBREAK, 64'd0);
            else if (csr == SYS_WFI || csr == SYS_STOP) raise_action(ACT_STOP, 64'd0);
            else if (csr == SYS_WRS_NTO || csr == SYS_WRS_STO) begin
               // wait-on-reservation hints retire as plain no-ops
            end else raise_action(ACT_ILLEGAL, {61'd0, f3});
         end
         F3_CSRRW: begin
            if (!access_float_csr(csr, OP_WRITE, src)) begin
               if (csr == CSR_TIME) raise_action(ACT_ILLEGAL, {52'd0, csr});
               else read_counter(csr, rs1, count, tval);
            end
         end
         F3_CSRRS: begin
            if (!access_float_csr(csr, OP_SET, src)) read_counter(csr, rs1, count, tval);
         end
         F3_CSRRC: begin
            if (!access_float_csr(csr, OP_CLEAR, src)) begin
               if (csr == CSR_TIME) clear_time(rs1, tval);
               else raise_action(ACT_ILLEGAL, {61'd0, f3});
            end
         end
         F3_ZIMOP: begin
            if ((hi & MOP_MASK) == MOP_MATCH && (hi[0] || instr[24:22] == 3'b111))
               write_dest(64'd0);
            else raise_action(ACT_ILLEGAL, {61'd0, f3});
         end
         F3_CSRRWI: begin
            if (!access_float_csr(csr, OP_WRITE, imm)) begin
               if (csr == CSR_TIME) raise_action(ACT_ILLEGAL, {52'd0, csr});
               else report_unhandled(csr, rs1);
            end
         end
         F3_CSRRSI: begin
            if (!access_float_csr(csr, OP_SET, imm)) read_counter(csr, rs1, count, tval);
         end
         default: begin
            if (!access_float_csr(csr, OP_CLEAR, imm)) begin
               if (csr == CSR_TIME) clear_time(rs1, tval);
               else report_unhandled(csr, rs1);
            end
         end
      endcase
      return decoded;
   endfunction

   // ---------------------------------------------------------------------
   // Checking. Sample both channels at the rising edge; compare each result
   // transfer against the oldest prediction before queuing the new one.
   // ---------------------------------------------------------------------

   task automatic check_field(input string name, input logic [63:0] want,
                              input logic [63:0] got);
      if (want !== got) begin
         $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_results.size() == 0) begin
               $error("result transfer with no prediction pending");
               fail_count++;
            end else begin
               oldest = expected_results.pop_front();
               check_field("dest_write",   64'(oldest.dest_write),   64'(rsp_tuser[0]));
               check_field("dest_index",   64'(oldest.dest_index),   64'(rsp_tdata[4:0]));
               check_field("dest_value",   oldest.dest_value,        rsp_tdata[68:5]);
               check_field("action",       64'(oldest.action),       64'(rsp_tuser[3:1]));
               check_field("action_info",  oldest.action_info,       rsp_tdata[132:69]);
               check_field("source_index", 64'(oldest.source_index),
                           64'(rsp_tdata[137:133]));
            end
         end
         if (req_tvalid && req_tready)
            expected_results.insert(expected_results.size(), predict_system_op(req_tdata));
      end
   end

   // Stop the run when neither channel moves a transfer for too long.
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   // Receiver backpressure: switch among always-ready, coin flip, a fixed
   // one-in-four stall and mostly-stalled, each for a random stretch.
   always @(negedge clock) begin
      if (rx_left == 0) begin
         rx_mode = $urandom_range(0, 3);
         rx_left = $urandom_range(16, 80);
      end
      rx_left--;
      rx_tick++;
      case (rx_mode)
         0:       rsp_tready <= 1'b1;
         1:       rsp_tready <= ($urandom_range(0, 1) == 1);
         2:       rsp_tready <= (rx_tick % 4 != 3);
         default: rsp_tready <= ($urandom_range(0, 3) == 0);
      endcase
   end

   // ---------------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------------

   function automatic logic [31:0] encode_system(input logic [11:0] csr, input logic [4:0] rs1,
                                                 input logic [2:0] f3, input logic [4:0] rd);
      return {csr, rs1, f3, rd, OPC_SYSTEM};
   endfunction

   // Drive one request from a falling edge and hold it until the transfer;
   // return on the falling edge that follows. Bursts end in a random gap.
   task automatic send_instr(input logic [31:0] instr, input logic [63:0] src,
                             input logic [63:0] a7, input logic [63:0] count,
                             input logic [63:0] tval);
      int unsigned gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 9) < 4) ? 0 : $urandom_range(1, 12);
         if (gap != 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         burst_left = $urandom_range(1, 48);
      end
      burst_left--;
      req_tdata  <= {tval, count, a7, src, instr};
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   // Hold off the sender until every predicted result has been taken.
   task automatic wait_for_drain();
      req_tvalid <= 1'b0;
      while (expected_results.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   function automatic logic [63:0] random_word();
      case ($urandom_range(0, 7))
         0:       return 64'd0;
         1:       return {64{1'b1}};
         2:       return 64'($urandom_range(0, 63));
         default: return {$urandom, $urandom};
      endcase
   endfunction

   task automatic test_privileged();
      send_instr(encode_system(SYS_ECALL, 5'd0, F3_PRIV, 5'd0), 64'd0, {64{1'b1}}, 64'd0, 64'd0);
      send_instr(encode_system(SYS_ECALL, 5'd31, F3_PRIV, 5'd31), {64{1'b1}}, 64'd0,
                 64'd5, 64'd6);
      send_instr(encode_system(SYS_EBREAK, 5'd0, F3_PRIV, 5'd0), 64'd0, 64'd9, 64'd0, 64'd0);
      send_instr(encode_system(SYS_WFI, 5'd0, F3_PRIV, 5'd0), 64'd0, 64'd9, 64'd0, 64'd0);
      send_instr(encode_system(SYS_STOP, 5'd0, F3_PRIV, 5'd0), 64'd0, 64'd9, 64'd0, 64'd0);
      send_instr(encode_system(SYS_WRS_NTO, 5'd0, F3_PRIV, 5'd3), 64'd0, 64'd9, 64'd0, 64'd0);
      send_instr(encode_system(SYS_WRS_STO, 5'd0, F3_PRIV, 5'd3), 64'd0, 64'd9, 64'd0, 64'd0);
      // an unknown funct3-0 code (sret) faults with funct3 as info
      send_instr(encode_system(12'h102, 5'd0, F3_PRIV, 5'd0), 64'd0, 64'd9, 64'd0, 64'd0);
   endtask

   task automatic test_float_csrs();
      // full write of fcsr keeps only its low byte
      send_instr(encode_system(CSR_FCSR, 5'd2, F3_CSRRW, 5'd1), {64{1'b1}}, 64'd0, 64'd0, 64'd0);
      send_instr(encode_system(CSR_FFLAGS, 5'd0, F3_CSRRS, 5'd3), 64'd0, 64'd0, 64'd0, 64'd0);
      // rd equal to rs1 still clears with the old source value
      send_instr(encode_system(CSR_FRM, 5'd4, F3_CSRRC, 5'd4), 64'hFFFF_FFFF_0000_0005,
                 64'd0, 64'd0, 64'd0);
      // frm takes the low three bits of the immediate; rd = x0 is not written
      send_instr(encode_system(CSR_FRM, 5'd31, F3_CSRRWI, 5'd0), 64'd0, 64'd0, 64'd0, 64'd0);
      send_instr(encode_system(CSR_FFLAGS, 5'd21, F3_CSRRCI, 5'd6), 64'd0, 64'd0, 64'd0, 64'd0);
      send_instr(encode_system(CSR_FCSR, 5'd10, F3_CSRRSI, 5'd31), 64'd0, 64'd0, 64'd0, 64'd0);
   endtask

   task automatic test_counters();
      send_instr(encode_system(CSR_CYCLE, 5'd0, F3_CSRRS, 5'd7), 64'd0, 64'd0,
                 {64{1'b1}}, 64'd0);
      // instret into x0 with a zero source is the UNIMP idiom
      send_instr(encode_system(CSR_INSTRET, 5'd0, F3_CSRRS, 5'd0), 64'd0, 64'd0, 64'd1, 64'd0);
      send_instr(encode_system(CSR_CYCLE, 5'd3, F3_CSRRW, 5'd0), 64'd0, 64'd0, 64'd1, 64'd0);
      send_instr(encode_system(CSR_INSTRETH, 5'd0, F3_CSRRSI, 5'd8), 64'd0, 64'd0,
                 64'hDEAD_BEEF_1234_5678, 64'd0);
      send_instr(encode_system(CSR_CYCLEH, 5'd0, F3_CSRRS, 5'd0), 64'd0, 64'd0,
                 64'hDEAD_BEEF_1234_5678, 64'd0);
      send_instr(encode_system(CSR_TIME, 5'd0, F3_CSRRS, 5'd9), 64'd0, 64'd0, 64'd0,
                 {64{1'b1}});
      send_instr(encode_system(CSR_TIME, 5'd1, F3_CSRRC, 5'd9), 64'd0, 64'd0, 64'd0, 64'd3);
      send_instr(encode_system(CSR_TIME, 5'd0, F3_CSRRWI, 5'd9), 64'd0, 64'd0, 64'd0, 64'd3);
      send_instr(encode_system(CSR_TIMEH, 5'd0, F3_CSRRS, 5'd10), 64'd0, 64'd0, 64'd0,
                 64'h8000_0001_0000_0000);
   endtask

   task automatic test_csr_faults();
      send_instr(encode_system(12'h300, 5'd1, F3_CSRRS, 5'd2), 64'd0, 64'd0, 64'd0, 64'd0);
      // CSRRW on a plain user CSR falls through to the read-and-set path
      send_instr(encode_system(12'h015, 5'd17, F3_CSRRW, 5'd2), 64'd1, 64'd0, 64'd0, 64'd0);
      send_instr(encode_system(12'h015, 5'd17, F3_CSRRC, 5'd2), 64'd1, 64'd0, 64'd0, 64'd0);
      send_instr(encode_system(12'h0FF, 5'd31, F3_CSRRCI, 5'd31), 64'd0, 64'd0, 64'd0, 64'd0);
   endtask

   task automatic test_zimop();
      send_instr({7'b1000000, 3'b111, 2'b01, 5'd4, F3_ZIMOP, 5'd12, OPC_SYSTEM},
                 {64{1'b1}}, 64'd0, 64'd0, 64'd0);
      send_instr({7'b1110111, 5'b00000, 5'd4, F3_ZIMOP, 5'd13, OPC_SYSTEM},
                 {64{1'b1}}, 64'd0, 64'd0, 64'd0);
      send_instr({7'b0000000, 5'b11111, 5'd4, F3_ZIMOP, 5'd14, OPC_SYSTEM},
                 {64{1'b1}}, 64'd0, 64'd0, 64'd0);
   endtask

   // Mostly well-formed SYSTEM instructions aimed at the decoded CSRs, with
   // some fully random words and foreign opcodes mixed in.
   task automatic test_random_stream(input int unsigned count_items);
      logic [31:0] instr;
      logic [11:0] csr;
      logic [6:0]  hi;
      logic [2:0]  f3;
      logic [4:0]  rd;
      logic [4:0]  rs1;
      for (int unsigned i = 0; i < count_items; i++) begin
         if (i == count_items / 2) wait_for_drain();
         f3  = 3'($urandom_range(0, 7));
         rd  = ($urandom_range(0, 3) == 0) ? 5'd0 : 5'($urandom);
         rs1 = ($urandom_range(0, 3) == 0) ? 5'd0 : 5'($urandom);
         case ($urandom_range(0, 15))
            0, 1, 2: csr = CSR_FFLAGS;
            3, 4:    csr = CSR_FRM;
            5, 6:    csr = CSR_FCSR;
            7:       csr = CSR_CYCLE;
            8:       csr = CSR_INSTRET;
            9:       csr = CSR_CYCLEH;
            10:      csr = CSR_INSTRETH;
            11:      csr = CSR_TIME;
            12:      csr = CSR_TIMEH;
            13: begin
               case ($urandom_range(0, 5))
                  0:       csr = SYS_ECALL;
                  1:       csr = SYS_WFI;
                  2:       csr = SYS_STOP;
                  3:       csr = SYS_WRS_NTO;
                  4:       csr = SYS_WRS_STO;
                  default: csr = 12'($urandom);
               endcase
               if ($urandom_range(0, 1) == 1) f3 = F3_PRIV;
            end
            14:      csr = 12'($urandom);
            default: csr = 12'($urandom) & ~CSR_PRIV_MASK;
         endcase
         instr = encode_system(csr, rs1, f3, rd);
         if (f3 == F3_ZIMOP && $urandom_range(0, 2) != 0) begin
            // keep the may-be-op pattern, randomize the free bits
            hi = {1'b1, 1'($urandom), 2'b00, 3'($urandom)};
            instr[31:25] = hi;
            if (!hi[0] && $urandom_range(0, 3) != 0) instr[24:22] = 3'b111;
         end
         if ($urandom_range(0, 3) == 0) instr[6:0] = 7'($urandom);
         if ($urandom_range(0, 99) < 8) instr = $urandom;
         send_instr(instr, random_word(), random_word(), random_word(), random_word());
      end
   endtask

   initial begin
      repeat (4) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_privileged();
      test_float_csrs();
      test_counters();
      test_csr_faults();
      test_zimop();
      test_random_stream(RANDOM_ITEMS);
      // Let the last results drain, then report the verdict.
      wait_for_drain();
      if (fail_count == 0 && expected_results.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

[sim.f]
sv/rvsc_pkg.sv
sv/riscv_system_csr_unit_top.sv
tb/sv/riscv_system_csr_unit_top_test.sv
